>>> src/complete_linkage_coassign_cluster_unit_assert.svh
// Assertion macros for the clustering unit.
// Define ASSERT_OFF to compile the checks out.
`ifndef COMPLETE_LINKAGE_COASSIGN_CLUSTER_UNIT_ASSERT_SVH
`define COMPLETE_LINKAGE_COASSIGN_CLUSTER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// Antecedent implies consequent in the same cycle.
`define CCL_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ccl assertion failed");
// Antecedent implies consequent in the next cycle.
`define CCL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ccl assertion failed");
`else
`define CCL_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define CCL_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> src/ccl_pkg.sv
// ----------------------------------------------------------------------------
// ccl_pkg
// Shared types and constants of the co-assignment clustering unit.
// ----------------------------------------------------------------------------
package ccl_pkg;

  localparam int ID_W    = 7;
  localparam int ITEMS_W = 7;
  localparam int RUNS_W  = 9;

  localparam logic [ITEMS_W-1:0] ITEMS_RESET = 7'd64;
  localparam logic [RUNS_W-1:0]  RUNS_RESET  = 9'd256;

  // Register index codes (paddr bit 2)
  localparam logic REG_ITEMS = 1'b0;
  localparam logic REG_RUNS  = 1'b1;

  // Clamped configuration seen by the sequencer
  typedef struct packed {
    logic [ITEMS_W-1:0] n_eff;
    logic [RUNS_W-1:0]  r_eff;
    logic               wr;
  } cfg_t;

endpackage

>>> src/ccl_if.sv
// ----------------------------------------------------------------------------
// ccl_if
// Valid/ready channels for label beats and merge result beats.
// ----------------------------------------------------------------------------
interface ccl_label_if;
  logic       valid;
  logic       ready;
  logic [7:0] label;

  modport source (output valid, output label, input ready);
  modport sink (input valid, input label, output ready);
endinterface

interface ccl_merge_if;
  logic       valid;
  logic       ready;
  logic [6:0] first_id;
  logic [6:0] second_id;
  logic [8:0] agree_count;
  logic       last_merge;

  modport source (output valid, output first_id, output second_id,
                  output agree_count, output last_merge, input ready);
  modport sink (input valid, input first_id, input second_id,
                input agree_count, input last_merge, output ready);
endinterface

>>> src/ccl_ram.sv
// ----------------------------------------------------------------------------
// ccl_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ccl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/ccl_cfg.sv
// ----------------------------------------------------------------------------
// ccl_cfg
// APB register file: item count and run count, clamped to their ranges.
// ----------------------------------------------------------------------------
module ccl_cfg #(
  parameter int MAX_ITEMS = 64,
  parameter int MAX_RUNS  = 256
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  output ccl_pkg::cfg_t cfg
);
  import ccl_pkg::*;

  logic [ITEMS_W-1:0] num_items;
  logic [RUNS_W-1:0]  num_runs;
  logic               wr;

  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      num_items <= ITEMS_RESET;
      num_runs  <= RUNS_RESET;
    end else if (wr) begin
      case (paddr[2])
        REG_ITEMS: num_items <= pwdata[ITEMS_W-1:0];
        REG_RUNS:  num_runs  <= pwdata[RUNS_W-1:0];
        default:   num_items <= num_items;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (paddr[2])
      REG_ITEMS: prdata = {25'd0, num_items};
      REG_RUNS:  prdata = {23'd0, num_runs};
      default:   prdata = 32'd0;
    endcase
  end

  // Clamp to legal ranges
  always_comb begin
    cfg.wr = wr;
    if (num_items < 7'd2) begin
      cfg.n_eff = 7'd2;
    end else if (32'(num_items) > MAX_ITEMS) begin
      cfg.n_eff = ITEMS_W'(MAX_ITEMS);
    end else begin
      cfg.n_eff = num_items;
    end
    if (num_runs == 9'd0) begin
      cfg.r_eff = 9'd1;
    end else if (32'(num_runs) > MAX_RUNS) begin
      cfg.r_eff = RUNS_W'(MAX_RUNS);
    end else begin
      cfg.r_eff = num_runs;
    end
  end

endmodule

>>> src/complete_linkage_coassign_cluster_unit.sv
// Labels load one beat per cycle while in the load state: N*R beats fill
// the label memory. The final beat starts clustering: first the pair
// counts, streamed through the label memory read port, then per merge a
// scan over the active pairs and an update of each group.
// One result beat per merge, N-1 in all. Reset sets N=64, R=256; no sweep.
`include "complete_linkage_coassign_cluster_unit_assert.svh"
// ----------------------------------------------------------------------------
// complete_linkage_coassign_cluster_unit
// Co-assignment similarity and complete-linkage agglomeration, sequenced
// over shared memories.
// ----------------------------------------------------------------------------
module complete_linkage_coassign_cluster_unit #(
  parameter int MAX_ITEMS  = 64,
  parameter int MAX_RUNS   = 256,
  parameter int LABEL_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  ccl_label_if.sink   sample,
  ccl_merge_if.source result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ccl_pkg::*;

  localparam int IW = $clog2(MAX_ITEMS);
  localparam int RW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
  localparam int CW = $clog2(MAX_RUNS + 1);
  localparam int LAB_DEPTH = 1 << (IW + RW);
  localparam int SIM_DEPTH = 1 << (2 * IW);

  localparam logic [4:0] S_LOAD = 5'd0;
  localparam logic [4:0] S_SIM  = 5'd1;
  localparam logic [4:0] S_SDRN = 5'd2;
  localparam logic [4:0] S_INIT = 5'd3;
  localparam logic [4:0] S_I0   = 5'd4;
  localparam logic [4:0] S_I1   = 5'd5;
  localparam logic [4:0] S_J0   = 5'd6;
  localparam logic [4:0] S_J1   = 5'd7;
  localparam logic [4:0] S_J2   = 5'd8;
  localparam logic [4:0] S_E0   = 5'd9;
  localparam logic [4:0] S_E1   = 5'd10;
  localparam logic [4:0] S_E2   = 5'd11;
  localparam logic [4:0] S_U0   = 5'd12;
  localparam logic [4:0] S_U1   = 5'd13;
  localparam logic [4:0] S_U2   = 5'd14;
  localparam logic [4:0] S_U3   = 5'd15;
  localparam logic [4:0] S_APP  = 5'd16;

  cfg_t cfg;

  ccl_cfg #(.MAX_ITEMS(MAX_ITEMS), .MAX_RUNS(MAX_RUNS)) u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  // Sequencer registers
  logic [4:0]       st;
  logic [IW-1:0]    item;
  logic [RW-1:0]    run;
  logic [IW-1:0]    pi, pj;
  logic [RW-1:0]    k;
  logic             kv;
  logic [CW-1:0]    cnt;
  logic [IW-1:0]    i, j, w;
  logic [IW:0]      acnt;
  logic [IW-1:0]    midx;
  logic             first;
  logic [CW-1:0]    best, m1;
  logic [IW-1:0]    ba, bb, sa, sb, si, sj, sk;
  logic [ID_W-1:0]  fid;
  logic             ov;
  logic [ID_W-1:0]  o_first, o_second;
  logic [CW-1:0]    o_count;
  logic             o_last;

  // Memory ports
  logic                  lab_we;
  logic [IW+RW-1:0]      lab_waddr;
  logic [LABEL_BITS-1:0] lab_wdata, lab_a, lab_b;
  logic                  ord_we;
  logic [IW-1:0]         ord_waddr, ord_wdata, ord_raddr, ord_rd;
  logic                  id_we;
  logic [IW-1:0]         id_waddr, id_raddr;
  logic [ID_W-1:0]       id_wdata, id_rd;
  logic                  sim_we;
  logic [2*IW-1:0]       sim_waddr, sim_raddr;
  logic [CW-1:0]         sim_wdata, sim_rd;

  logic             eq, accept, last, take, out_free, emit;
  logic [CW-1:0]    vmin;
  logic [CW+8:0]    count_ext;

  function automatic logic [2*IW-1:0] pair(input logic [IW-1:0] a,
                                           input logic [IW-1:0] b);
    pair = (a < b) ? {a, b} : {b, a};
  endfunction

  ccl_ram #(.WIDTH(LABEL_BITS), .DEPTH(LAB_DEPTH)) u_lab_a (
    .clk(clk), .we(lab_we), .waddr(lab_waddr), .wdata(lab_wdata),
    .raddr({pi, k}), .rdata(lab_a)
  );
  ccl_ram #(.WIDTH(LABEL_BITS), .DEPTH(LAB_DEPTH)) u_lab_b (
    .clk(clk), .we(lab_we), .waddr(lab_waddr), .wdata(lab_wdata),
    .raddr({pj, k}), .rdata(lab_b)
  );
  ccl_ram #(.WIDTH(IW), .DEPTH(MAX_ITEMS)) u_ord (
    .clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
    .raddr(ord_raddr), .rdata(ord_rd)
  );
  ccl_ram #(.WIDTH(ID_W), .DEPTH(MAX_ITEMS)) u_id (
    .clk(clk), .we(id_we), .waddr(id_waddr), .wdata(id_wdata),
    .raddr(id_raddr), .rdata(id_rd)
  );
  ccl_ram #(.WIDTH(CW), .DEPTH(SIM_DEPTH)) u_sim (
    .clk(clk), .we(sim_we), .waddr(sim_waddr), .wdata(sim_wdata),
    .raddr(sim_raddr), .rdata(sim_rd)
  );

  assign sample.ready = (st == S_LOAD);
  assign accept    = sample.valid & sample.ready;
  assign lab_we    = accept;
  assign lab_waddr = {item, run};
  assign lab_wdata = LABEL_BITS'({8'd0, sample.label});
  assign eq        = (lab_a == lab_b);
  assign vmin      = (m1 < sim_rd) ? m1 : sim_rd;
  assign last      = (8'(midx) + 8'd2) == 8'(cfg.n_eff);
  assign take      = first || ((midx == '0) ? (sim_rd > best) : (sim_rd >= best));
  assign out_free  = !ov || result.ready;
  assign emit      = (st == S_E2) && out_free;

  assign count_ext          = {9'd0, o_count};
  assign result.valid       = ov;
  assign result.first_id    = o_first;
  assign result.second_id   = o_second;
  assign result.agree_count = count_ext[8:0];
  assign result.last_merge  = o_last;

  // Memory address and write selection
  always_comb begin
    ord_we    = 1'b0;
    ord_waddr = w;
    ord_wdata = sk;
    ord_raddr = j;
    id_we     = 1'b0;
    id_waddr  = pi;
    id_wdata  = ID_W'(pi);
    id_raddr  = sa;
    sim_we    = 1'b0;
    sim_waddr = {pi, pj};
    sim_wdata = cnt + CW'(eq);
    sim_raddr = pair(si, ord_rd);
    case (st)
      S_SDRN: sim_we = 1'b1;
      S_INIT: begin
        ord_we    = 1'b1;
        ord_waddr = pi;
        ord_wdata = pi;
        id_we     = 1'b1;
      end
      S_I0: ord_raddr = i;
      S_E1, S_E2: id_raddr = sb;
      S_U1: sim_raddr = pair(sa, ord_rd);
      S_U2: sim_raddr = pair(sb, sk);
      S_U3: begin
        ord_we    = 1'b1;
        sim_we    = 1'b1;
        sim_waddr = pair(sa, sk);
        sim_wdata = vmin;
      end
      S_APP: begin
        ord_we    = 1'b1;
        ord_wdata = sa;
        id_we     = 1'b1;
        id_waddr  = sa;
        id_wdata  = cfg.n_eff + ID_W'(midx);
      end
      default: ord_we = 1'b0;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= S_LOAD;
      item <= '0;
      run  <= '0;
      kv   <= 1'b0;
      ov   <= 1'b0;
    end else begin
      // Load a new result beat, or drop the one taken
      if (emit) begin
        ov <= 1'b1;
      end else if (ov && result.ready) begin
        ov <= 1'b0;
      end
      kv <= (st == S_SIM);
      case (st)
        S_LOAD: begin
          if (cfg.wr) begin
            item <= '0;
            run  <= '0;
          end else if (accept) begin
            if (16'(run) == 16'(cfg.r_eff) - 16'd1) begin
              run <= '0;
              if (8'(item) == 8'(cfg.n_eff) - 8'd1) begin
                item <= '0;
                pi   <= '0;
                pj   <= IW'(1);
                k    <= '0;
                cnt  <= '0;
                st   <= S_SIM;
              end else begin
                item <= item + IW'(1);
              end
            end else begin
              run <= run + RW'(1);
            end
          end
        end
        // Stream one run per cycle, count agreements of the pair
        S_SIM: begin
          if (kv && eq) begin
            cnt <= cnt + CW'(1);
          end
          if (16'(k) == 16'(cfg.r_eff) - 16'd1) begin
            st <= S_SDRN;
          end else begin
            k <= k + RW'(1);
          end
        end
        S_SDRN: begin
          cnt <= '0;
          k   <= '0;
          if (8'(pj) == 8'(cfg.n_eff) - 8'd1) begin
            if (8'(pi) + 8'd2 == 8'(cfg.n_eff)) begin
              pi <= '0;
              st <= S_INIT;
            end else begin
              pi <= pi + IW'(1);
              pj <= pi + IW'(2);
              st <= S_SIM;
            end
          end else begin
            pj <= pj + IW'(1);
            st <= S_SIM;
          end
        end
        // Fill list with leaves
        S_INIT: begin
          if (8'(pi) == 8'(cfg.n_eff) - 8'd1) begin
            acnt  <= (IW+1)'(cfg.n_eff);
            midx  <= '0;
            i     <= '0;
            first <= 1'b1;
            st    <= S_I0;
          end else begin
            pi <= pi + IW'(1);
          end
        end
        S_I0: st <= S_I1;
        S_I1: begin
          si <= ord_rd;
          j  <= i + IW'(1);
          st <= S_J0;
        end
        S_J0: st <= S_J1;
        S_J1: begin
          sj <= ord_rd;
          st <= S_J2;
        end
        // Compare pair similarity against the running best
        S_J2: begin
          first <= 1'b0;
          if (take) begin
            best <= sim_rd;
            ba   <= i;
            bb   <= j;
            sa   <= si;
            sb   <= sj;
          end
          if ((IW+1)'(j) == acnt - (IW+1)'(1)) begin
            if ((IW+1)'(i) + (IW+1)'(2) == acnt) begin
              st <= S_E0;
            end else begin
              i  <= i + IW'(1);
              st <= S_I0;
            end
          end else begin
            j  <= j + IW'(1);
            st <= S_J0;
          end
        end
        S_E0: st <= S_E1;
        S_E1: begin
          fid <= id_rd;
          st  <= S_E2;
        end
        // Hold until the output register frees up
        S_E2: begin
          if (out_free) begin
            o_first  <= fid;
            o_second <= id_rd;
            o_count  <= best;
            o_last   <= last;
            j        <= '0;
            w        <= '0;
            st       <= last ? S_LOAD : S_U0;
          end
        end
        S_U0: st <= S_U1;
        S_U1: begin
          sk <= ord_rd;
          if (j == ba || j == bb) begin
            if ((IW+1)'(j) == acnt - (IW+1)'(1)) begin
              st <= S_APP;
            end else begin
              j  <= j + IW'(1);
              st <= S_U0;
            end
          end else begin
            st <= S_U2;
          end
        end
        S_U2: begin
          m1 <= sim_rd;
          st <= S_U3;
        end
        // Write linkage minimum and compact the list
        S_U3: begin
          w <= w + IW'(1);
          if ((IW+1)'(j) == acnt - (IW+1)'(1)) begin
            st <= S_APP;
          end else begin
            j  <= j + IW'(1);
            st <= S_U0;
          end
        end
        S_APP: begin
          acnt  <= (IW+1)'(w) + (IW+1)'(1);
          midx  <= midx + IW'(1);
          i     <= '0;
          first <= 1'b1;
          st    <= S_I0;
        end
        default: st <= S_LOAD;
      endcase
    end
  end

  // Checks
  `CCL_ASSERT_IMPL(a_emit_src, clk, rst, $rose(ov), $past(st) == S_E2)
  `CCL_ASSERT_IMPL(a_cnt_range, clk, rst, st == S_SDRN, 16'(cnt) < 16'(cfg.r_eff) + 16'd1)
  `CCL_ASSERT_IMPL(a_scan_order, clk, rst, st == S_J2, (i < j) && ((IW+1)'(j) < acnt))
  `CCL_ASSERT_NEXT(a_load_exit, clk, rst, (st == S_E2) && out_free && last, st == S_LOAD)

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the co-assignment clustering unit. Loads label
// sets over several item/run settings and idle patterns, predicts each merge
// beat with an in-bench complete-linkage model and compares field by field.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ccl_pkg::*;

  localparam logic [2:0] ADDR_ITEMS = {REG_ITEMS, 2'b00};
  localparam logic [2:0] ADDR_RUNS  = {REG_RUNS, 2'b00};
  localparam int MAXN = 64;
  localparam int MAXR = 256;

  typedef struct {
    logic [6:0] first_id;
    logic [6:0] second_id;
    logic [8:0] agree_count;
    logic       last_merge;
  } merge_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  ccl_label_if lif ();
  ccl_merge_if mif ();

  complete_linkage_coassign_cluster_unit u_top (
    .clk(clk), .rst(rst), .sample(lif), .result(mif),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Stimulus and model state
  logic [7:0]  label_q[$];
  merge_t      merge_q[$];
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          errors = 0;
  int          beats_in = 0;
  int          merges_seen = 0;
  int          sets_done = 0;

  logic [6:0]  reg_items = ITEMS_RESET;
  logic [8:0]  reg_runs = RUNS_RESET;
  int          load_pos = 0;
  logic [7:0]  labels_mem[MAXN*MAXR];
  int          sim[MAXN][MAXN];
  int          order_ids[MAXN];
  int          slots[MAXN];

  function automatic int items_eff();
    return (reg_items < 2) ? 2 : (reg_items > MAXN) ? MAXN : int'(reg_items);
  endfunction

  function automatic int runs_eff();
    return (reg_runs < 1) ? 1 : (reg_runs > MAXR) ? MAXR : int'(reg_runs);
  endfunction

  // Build pair counts, then agglomerate and queue one merge per step
  task automatic predict_merges();
    int n, r, c, ba, bb, best, v, sa, sb, m, w, act;
    merge_t e;
    n = items_eff();
    r = runs_eff();
    for (int i = 0; i < n; i++) begin
      sim[i][i] = 0;
      for (int j = i + 1; j < n; j++) begin
        c = 0;
        for (int k = 0; k < r; k++)
          if (labels_mem[i*r+k] == labels_mem[j*r+k]) c++;
        sim[i][j] = c;
        sim[j][i] = c;
      end
      order_ids[i] = i;
      slots[i] = i;
    end
    act = n;
    for (int mi = 0; mi + 1 < n; mi++) begin
      ba = 0;
      bb = 1;
      best = sim[slots[0]][slots[1]];
      for (int i = 0; i + 1 < act; i++)
        for (int j = i + 1; j < act; j++) begin
          v = sim[slots[i]][slots[j]];
          // first merge keeps the earliest maximum, later ones the last
          if ((mi == 0) ? (v > best) : (v >= best)) begin
            best = v;
            ba = i;
            bb = j;
          end
        end
      e.first_id = 7'(order_ids[ba]);
      e.second_id = 7'(order_ids[bb]);
      e.agree_count = 9'(best);
      e.last_merge = (mi + 2 == n);
      merge_q.push_back(e);
      sa = slots[ba];
      sb = slots[bb];
      for (int k = 0; k < act; k++) begin
        if (k == ba || k == bb) continue;
        m = sim[sa][slots[k]];
        if (sim[sb][slots[k]] < m) m = sim[sb][slots[k]];
        sim[sa][slots[k]] = m;
        sim[slots[k]][sa] = m;
      end
      w = 0;
      for (int k = 0; k < act; k++) begin
        if (k == ba || k == bb) continue;
        order_ids[w] = order_ids[k];
        slots[w] = slots[k];
        w++;
      end
      order_ids[w] = n + mi;
      slots[w] = sa;
      act = w + 1;
    end
  endtask

  // Drive label beats from the pending queue
  always @(posedge clk) begin
    if (rst) begin
      lif.valid <= 1'b0;
      lif.label <= '0;
    end else if (!lif.valid || lif.ready) begin
      if (label_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        lif.label <= label_q.pop_front();
        lif.valid <= 1'b1;
      end else begin
        lif.valid <= 1'b0;
      end
    end
  end

  // Store accepted labels; the last beat of a set triggers prediction
  always @(posedge clk) begin
    if (!rst && lif.valid && lif.ready) begin
      labels_mem[load_pos] = lif.label;
      load_pos++;
      beats_in++;
      if (load_pos >= items_eff() * runs_eff()) begin
        load_pos = 0;
        sets_done++;
        predict_merges();
      end
    end
  end

  // Random backpressure on the result side
  always @(posedge clk) begin
    if (rst) mif.ready <= 1'b0;
    else mif.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each merge beat with the oldest prediction
  always @(posedge clk) begin
    merge_t e;
    if (!rst && mif.valid && mif.ready) begin
      merges_seen++;
      if (merge_q.size() == 0) begin
        $error("merge beat with nothing predicted");
        errors++;
      end else begin
        e = merge_q.pop_front();
        if (mif.first_id !== e.first_id) begin
          $error("first_id: expected %0d, got %0d", e.first_id, mif.first_id);
          errors++;
        end
        if (mif.second_id !== e.second_id) begin
          $error("second_id: expected %0d, got %0d", e.second_id, mif.second_id);
          errors++;
        end
        if (mif.agree_count !== e.agree_count) begin
          $error("agree_count: expected %0d, got %0d", e.agree_count,
                 mif.agree_count);
          errors++;
        end
        if (mif.last_merge !== e.last_merge) begin
          $error("last_merge: expected %0d, got %0d", e.last_merge,
                 mif.last_merge);
          errors++;
        end
      end
    end
  end

  // Drain: no pending labels, nothing predicted, then a short pause
  task automatic wait_quiet();
    while (label_q.size() > 0 || lif.valid || merge_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Register write: setup cycle, access cycle; restarts the load
  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_ITEMS) reg_items = data[6:0];
    else reg_runs = data[8:0];
    load_pos = 0;
  endtask

  task automatic set_config(input int n, input int r);
    wait_quiet();
    reg_write(ADDR_ITEMS, n);
    reg_write(ADDR_RUNS, r);
  endtask

  // Queue one full set; alphabet 0 means any 8-bit label
  task automatic queue_set(input int alphabet);
    for (int i = 0; i < items_eff() * runs_eff(); i++)
      label_q.push_back(alphabet == 0 ? 8'($urandom_range(255))
                                      : 8'($urandom_range(alphabet - 1)));
  endtask

  initial begin
    int target;
    rst = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Smallest setting: agreeing pair, then all-zero pair
    set_config(2, 1);
    label_q.push_back(8'h00); label_q.push_back(8'h00);
    label_q.push_back(8'hFF); label_q.push_back(8'h00);
    // All-zero first step with three items
    set_config(3, 2);
    for (int i = 0; i < 6; i++) label_q.push_back(8'(i));
    // Clamp low on both registers
    set_config(0, 0);
    label_q.push_back(8'hAA); label_q.push_back(8'h55);
    // Partial load abandoned by a register write
    set_config(4, 2);
    label_q.push_back(8'h12); label_q.push_back(8'h34); label_q.push_back(8'h56);
    set_config(4, 2);
    queue_set(2);
    // Clamp high on items, the most merges
    set_config(127, 1);
    queue_set(2);

    // Random sets over four idle patterns
    target = beats_in + 300;
    for (int ph = 0; ph < 4; ph++) begin
      while (beats_in + label_q.size() < target - (3 - ph) * 75) begin
        set_config($urandom_range(2, 7), $urandom_range(1, 6));
        wait_quiet();
        case (ph)
          0: begin send_idle_pct = 0; recv_stall_pct = 0; end
          1: begin send_idle_pct = 72; recv_stall_pct = 0; end
          2: begin send_idle_pct = 0; recv_stall_pct = 72; end
          default: begin send_idle_pct = 22; recv_stall_pct = 22; end
        endcase
        repeat ($urandom_range(1, 3)) queue_set($urandom_range(0, 4));
      end
    end

    wait_quiet();
    repeat (50) @(posedge clk);
    $display("Covered %0d label beats in %0d sets, %0d merge beats checked.",
             beats_in, sets_done, merges_seen);
    $display("Settings ranged from 2 to 64 items and 1 to 6 runs, clamps included.");
    if (errors == 0 && merge_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #30ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/ccl_pkg.sv
src/ccl_if.sv
src/ccl_ram.sv
src/ccl_cfg.sv
src/complete_linkage_coassign_cluster_unit.sv
test/tb.sv
